[sv/grbp_pkg.sv]
`default_nettype none
package grbp_pkg;

  localparam int WORD_BITS   = 32;
  localparam int RUN_BITS    = 10;
  localparam int FILL_W      = $clog2(WORD_BITS + 1);
  localparam int FILLED_W    = $clog2(WORD_BITS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [RUN_BITS-1:0] run_length;
    logic                bit_val;
    logic                last;
  } region_t;

endpackage
`default_nettype wire

[sv/grbp_front.sv]
`default_nettype none
module grbp_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [grbp_pkg::RUN_BITS-1:0] run_length,
  input  wire                   glitch,
  input  wire                   last_region,
  output logic                  push,
  output grbp_pkg::region_t     push_item,
  input  wire                   q_full
);
  import grbp_pkg::*;

  logic    hold_valid;
  region_t hold;
  logic    keep;
  logic    hold_free;

  // zero-length regions that do not end the stream carry no work
  assign keep      = (hold.run_length != '0) || hold.last;
  assign push      = hold_valid && keep && !q_full;
  assign push_item = hold;
  assign in_stall  = hold_valid && keep && q_full;
  assign hold_free = !hold_valid || !keep || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hold_free) begin
      hold_valid <= in_valid;
    end
    if (hold_free && in_valid) begin
      hold.run_length <= run_length;
      hold.bit_val    <= !glitch;
      hold.last       <= last_region;
    end
  end

endmodule
`default_nettype wire

[sv/grbp_fifo.sv]
`default_nettype none
module grbp_fifo (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  grbp_pkg::region_t push_item,
  output logic              full,
  input  wire               pop,
  output logic              q_valid,
  output grbp_pkg::region_t q_item
);
  import grbp_pkg::*;

  region_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_item  = mem[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

[sv/grbp_back.sv]
`default_nettype none
module grbp_back (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            q_valid,
  input  grbp_pkg::region_t              q_item,
  output logic                           pop,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [grbp_pkg::WORD_BITS-1:0] word,
  output logic                           run_end,
  output logic                           stream_end
);
  import grbp_pkg::*;

  logic                  busy;
  logic [RUN_BITS-1:0]   remaining;
  logic                  bit_val;
  logic                  last_flag;
  logic [WORD_BITS-1:0]  acc;
  logic [FILLED_W-1:0]   filled;

  logic [FILL_W-1:0]     space;
  logic [FILL_W-1:0]     take;
  logic [FILL_W-1:0]     sum;
  logic                  full_word;
  logic [2*WORD_BITS-1:0] wide;
  logic [2*WORD_BITS-1:0] pad_wide;
  logic [WORD_BITS-1:0]  flush_word;
  logic [RUN_BITS-1:0]   rem_after;
  logic                  has_bits;
  logic                  emit;
  logic                  out_free;
  logic                  step;
  logic                  done;

  always_comb begin
    space     = FILL_W'(WORD_BITS) - FILL_W'(filled);
    if (RUN_BITS'(space) > remaining && remaining < RUN_BITS'(WORD_BITS)) begin
      take = FILL_W'(remaining);
    end else begin
      take = space;
    end
    sum       = FILL_W'(filled) + take;
    full_word = sum == FILL_W'(WORD_BITS);
    wide      = {{WORD_BITS{1'b0}}, acc} << take;
    if (bit_val) begin
      wide = wide | ~({(2*WORD_BITS){1'b1}} << take);
    end
    pad_wide   = {{WORD_BITS{1'b0}}, acc} << space;
    flush_word = pad_wide[WORD_BITS-1:0] | ({WORD_BITS{1'b1}} >> filled);
    rem_after  = remaining - RUN_BITS'(take);
    has_bits   = remaining != '0;
    emit       = busy && (has_bits ? full_word : last_flag);
    out_free   = !out_valid || !out_stall;
    step       = busy && (!emit || out_free);
    done       = step && (has_bits ? (rem_after == '0 && !last_flag) : 1'b1);
    pop        = q_valid && (!busy || done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
      filled    <= '0;
    end else begin
      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        if (has_bits && !full_word) begin
          acc    <= wide[WORD_BITS-1:0];
          filled <= sum[FILLED_W-1:0];
        end else begin
          acc    <= '0;
          filled <= '0;
        end
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
    if (pop) begin
      remaining <= q_item.run_length;
      bit_val   <= q_item.bit_val;
      last_flag <= q_item.last;
    end else if (step && has_bits) begin
      remaining <= rem_after;
    end
    if (step && emit) begin
      if (has_bits) begin
        word       <= wide[WORD_BITS-1:0];
        run_end    <= !last_flag && rem_after < RUN_BITS'(WORD_BITS);
        stream_end <= 1'b0;
      end else begin
        word       <= flush_word;
        run_end    <= 1'b1;
        stream_end <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/glitch_region_bit_packer.sv]
// glitch region bit packer
// input channel: in_valid / in_stall with run_length, glitch, last_region;
// one request is one region of cycles, expanded to one bit per cycle
// (1 normal, 0 glitched), packed first cycle into bit 31
// output channel: out_valid / out_stall with word, run_end, stream_end;
// run_end marks the last word that a non-last request completes, and the
// stream_end word, the padded word after the last region (rest all ones)
// an accepted request passes the queue write, the load and the step into
// the output register before its first word reaches the output, when
// that word completes in the first chunk
// the packer works a region in chunks, one step per chunk, a chunk ending
// at a word boundary or at the end of the region, plus one flush step on a
// last region; a region loads in the same cycle as its predecessor's last
// step, or as soon as it is queued when the packer was idle; at most one
// word leaves per cycle
// a four-entry queue lets new regions come in while the packer works
// reset clears the partial word, the queue, the hold flag and out_valid
// when out_stall is high a valid output word holds and the packer waits
// before its next word; a full queue raises in_stall while a region waits
`default_nettype none
module glitch_region_bit_packer (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [grbp_pkg::RUN_BITS-1:0]  run_length,
  input  wire                            glitch,
  input  wire                            last_region,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [grbp_pkg::WORD_BITS-1:0] word,
  output logic                           run_end,
  output logic                           stream_end
);
  import grbp_pkg::*;

  logic    push;
  region_t push_item;
  logic    q_full;
  logic    pop;
  logic    q_valid;
  region_t q_item;

  grbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .run_length  (run_length),
    .glitch      (glitch),
    .last_region (last_region),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  grbp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  grbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word       (word),
    .run_end    (run_end),
    .stream_end (stream_end)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue written while full");

  a_stream_end_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> run_end)
    else $error("stream end word without run end");

  a_pad_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> word[0])
    else $error("final word not padded with ones");

  a_skip_dropped: assert property (@(posedge clk) disable iff (rst)
    push |-> push_item.run_length != '0 || push_item.last)
    else $error("empty region queued");

endmodule
`default_nettype wire
